// ===== rtl/core/ubds_pkg.sv =====
// shared types and constants for the baud divisor search
package ubds_pkg;

  localparam int DVD_W    = 29;               // bus clock / 4
  localparam int DVS_W    = 32;               // widest divisor (the request)
  localparam int Q_W      = 17;               // capped divisor count, 0..65536
  localparam int OUT_W    = 16;
  localparam int MAX_DIV  = 65535;
  localparam logic [Q_W-1:0] Q_CAP = Q_W'(MAX_DIV + 1);

  // sideband that travels with a beat through the divider stages
  typedef struct packed {
    logic [DVS_W-1:0] t;
    logic [Q_W-1:0]   q;
    logic [DVD_W-1:0] v;
    logic [DVS_W-1:0] below_err;
    logic [DVD_W-1:0] above_err;
    logic             have_below;
    logic             have_above;
  } ctx_t;

endpackage

// ===== rtl/core/uart_baud_divisor_search.sv =====
// top level: baud divisor search as a four-divider pipeline
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  in       | in_valid / in_stall  | in_target_baud [31:0]
//  out      | out_valid / out_stall| out_divisor [15:0]
//  cfg      | cfg_wr_en            | cfg_wr_data [30:0] bus clock hz
//
// one beat per cycle in and out while out_stall does not hold the pipe: input register, three
// 29-stage dividers in series (one quotient bit per stage), two registers
// between them and the output register; the divider stage count sets the depth of the pipe
// the whole pipe advances together; out_stall with a full output register
// freezes every stage and raises in_stall, nothing is dropped or repeated
// synchronous active-low reset clears valid bits, bus clock to 80000000
module uart_baud_divisor_search
  import ubds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_target_baud,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_divisor,
  input  logic              cfg_wr_en,
  input  logic [30:0]       cfg_wr_data
);

  // achieved(d) = floor(G / (d+1)) with G = floor(F/4)
  // first d with achieved < T is floor(G/T), capped at 65536
  // above candidate v = G/q, its first divisor floor(G/(v+1))

  logic [30:0]      bus_clk_r;
  logic [DVD_W-1:0] g;
  logic             en;

  // stage a: input register
  logic             a_vld_r;
  logic [31:0]      a_t_r;
  ctx_t             a_ctx;

  // divider one: G / T
  logic             d1_vld;
  logic [DVD_W-1:0] d1_quo;
  ctx_t             d1_ctx;

  // stage b: capped q
  logic             b_vld_r;
  ctx_t             b_ctx_r;
  ctx_t             b_ctx_nxt;

  // dividers two and three: G / q and G / (q+1)
  logic             d2_vld;
  logic             d3_vld;
  logic [DVD_W-1:0] d2_quo;
  logic [DVD_W-1:0] d3_quo;
  ctx_t             d2_ctx;
  ctx_t             d3_ctx;
  logic [DVS_W-1:0] d2_dvs;

  // stage c: errors and flags
  logic             c_vld_r;
  ctx_t             c_ctx_r;
  ctx_t             c_ctx_nxt;

  // divider four: G / (v+1)
  logic             d4_vld;
  logic [DVD_W-1:0] d4_quo;
  ctx_t             d4_ctx;

  // output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_divisor_r;
  logic [OUT_W-1:0] out_divisor_nxt;
  logic             use_above;
  logic             have_best;
  logic [DVS_W-1:0] best_err;
  logic [DVS_W-1:0] limit;

  assign g        = bus_clk_r[30:2];
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_clk_r <= 31'd80000000;
    end else if (cfg_wr_en) begin
      bus_clk_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
    if (en) begin
      a_t_r <= in_target_baud;
    end
  end

  always_comb begin
    a_ctx   = '0;
    a_ctx.t = a_t_r;
  end

  // a zero request divides by one; its q is forced to the cap below
  ubds_div u_div_below (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_vld_r),
    .in_dvd    (g),
    .in_dvs    ((a_t_r == '0) ? DVS_W'(1) : a_t_r),
    .in_ctx    (a_ctx),
    .out_valid (d1_vld),
    .out_quo   (d1_quo),
    .out_ctx   (d1_ctx)
  );

  always_comb begin
    b_ctx_nxt = d1_ctx;
    if ((d1_ctx.t == '0) || (d1_quo > DVD_W'(Q_CAP))) begin
      b_ctx_nxt.q = Q_CAP;
    end else begin
      b_ctx_nxt.q = d1_quo[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= d1_vld;
    end
    if (en) begin
      b_ctx_r <= b_ctx_nxt;
    end
  end

  // q of zero has no above candidate; divide by one to stay defined
  assign d2_dvs = (b_ctx_r.q == '0) ? DVS_W'(1) : DVS_W'(b_ctx_r.q);

  ubds_div u_div_above_rate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_vld_r),
    .in_dvd    (g),
    .in_dvs    (d2_dvs),
    .in_ctx    (b_ctx_r),
    .out_valid (d2_vld),
    .out_quo   (d2_quo),
    .out_ctx   (d2_ctx)
  );

  ubds_div u_div_below_rate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_vld_r),
    .in_dvd    (g),
    .in_dvs    (DVS_W'(b_ctx_r.q) + DVS_W'(1)),
    .in_ctx    (b_ctx_r),
    .out_valid (d3_vld),
    .out_quo   (d3_quo),
    .out_ctx   (d3_ctx)
  );

  always_comb begin
    c_ctx_nxt            = d2_ctx;
    c_ctx_nxt.v          = d2_quo;
    c_ctx_nxt.have_below = d2_ctx.q <= Q_W'(MAX_DIV);
    c_ctx_nxt.have_above = d2_ctx.q != '0;
    // rate at q is strictly below the request when it exists
    c_ctx_nxt.below_err  = d2_ctx.t - DVS_W'(d3_quo);
    // rate at q-1 is at or above the request
    c_ctx_nxt.above_err  = DVD_W'(DVS_W'(d2_quo) - d2_ctx.t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= d2_vld;
    end
    if (en) begin
      c_ctx_r <= c_ctx_nxt;
    end
  end

  ubds_div u_div_first_above (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_vld_r),
    .in_dvd    (g),
    .in_dvs    (DVS_W'(c_ctx_r.v) + DVS_W'(1)),
    .in_ctx    (c_ctx_r),
    .out_valid (d4_vld),
    .out_quo   (d4_quo),
    .out_ctx   (d4_ctx)
  );

  // pick the nearer side, the above side on a tie (its divisor is smaller); zero if no side or error >= 2x bus clock
  always_comb begin
    limit     = {bus_clk_r, 1'b0};
    use_above = d4_ctx.have_above &&
                (!d4_ctx.have_below ||
                 (DVS_W'(d4_ctx.above_err) <= d4_ctx.below_err));
    have_best = d4_ctx.have_above || d4_ctx.have_below;
    best_err  = use_above ? DVS_W'(d4_ctx.above_err) : d4_ctx.below_err;
    if (!have_best || (best_err >= limit)) begin
      out_divisor_nxt = '0;
    end else if (use_above) begin
      out_divisor_nxt = d4_quo[OUT_W-1:0];
    end else begin
      out_divisor_nxt = d4_ctx.q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d4_vld;
    end
    if (en) begin
      out_divisor_r <= out_divisor_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_divisor = out_divisor_r;

  // the pipe only holds back input when a finished beat waits
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting output beat");

  // the capped divisor count never passes the cap
  a_q_capped: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |-> (b_ctx_r.q <= Q_CAP))
    else $error("divisor count beyond cap");

  // a frozen pipe keeps its last-stage beat
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && d4_vld) |=> (d4_vld && $stable(d4_quo)))
    else $error("last divider stage moved while frozen");

  // a beat leaving divider two is taken into stage c
  a_step_c: assert property (@(posedge clk) disable iff (!rst_n)
    (en && d2_vld) |=> c_vld_r)
    else $error("beat lost between dividers");

  // the two parallel dividers carry the same beat
  a_par_align: assert property (@(posedge clk) disable iff (!rst_n)
    (d3_vld == d2_vld) && (!d2_vld || (d3_ctx == d2_ctx)))
    else $error("parallel dividers out of step");

endmodule

// ===== rtl/core/ubds_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module ubds_div
  import ubds_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DVD_W-1:0] in_dvd,
  input  logic [DVS_W-1:0] in_dvs,
  input  ctx_t             in_ctx,
  output logic             out_valid,
  output logic [DVD_W-1:0] out_quo,
  output ctx_t             out_ctx
);

  logic             vld_r [DVD_W];
  logic [DVS_W-1:0] rem_r [DVD_W];
  logic [DVD_W-1:0] dvd_r [DVD_W];
  logic [DVD_W-1:0] quo_r [DVD_W];
  logic [DVS_W-1:0] dvs_r [DVD_W];
  ctx_t             ctx_r [DVD_W];

  for (genvar s = 0; s < DVD_W; s++) begin : g_stage
    logic             src_vld;
    logic [DVS_W-1:0] src_rem;
    logic [DVD_W-1:0] src_dvd;
    logic [DVD_W-1:0] src_quo;
    logic [DVS_W-1:0] src_dvs;
    ctx_t             src_ctx;
    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W-1:0] rem_nxt;

    if (s == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_rem = '0;
      assign src_dvd = in_dvd;
      assign src_quo = '0;
      assign src_dvs = in_dvs;
      assign src_ctx = in_ctx;
    end else begin : g_next
      assign src_vld = vld_r[s-1];
      assign src_rem = rem_r[s-1];
      assign src_dvd = dvd_r[s-1];
      assign src_quo = quo_r[s-1];
      assign src_dvs = dvs_r[s-1];
      assign src_ctx = ctx_r[s-1];
    end

    always_comb begin
      trial   = {src_rem, src_dvd[DVD_W-1]};
      ge      = trial >= {1'b0, src_dvs};
      rem_nxt = ge ? DVS_W'(trial - {1'b0, src_dvs}) : trial[DVS_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_vld;
      end
      if (en) begin
        rem_r[s] <= rem_nxt;
        dvd_r[s] <= {src_dvd[DVD_W-2:0], 1'b0};
        quo_r[s] <= {src_quo[DVD_W-2:0], ge};
        dvs_r[s] <= src_dvs;
        ctx_r[s] <= src_ctx;
      end
    end
  end

  assign out_valid = vld_r[DVD_W-1];
  assign out_quo   = quo_r[DVD_W-1];
  assign out_ctx   = ctx_r[DVD_W-1];

endmodule
